### rtl/ntc_pkg.sv
`default_nettype none

package ntc_pkg;

    localparam logic [3:0] TC_BOOL  = 4'd1;
    localparam logic [3:0] TC_U_VAR = 4'd2;
    localparam logic [3:0] TC_U8    = 4'd3;
    localparam logic [3:0] TC_U16   = 4'd4;
    localparam logic [3:0] TC_U32   = 4'd5;
    localparam logic [3:0] TC_U64   = 4'd6;
    localparam logic [3:0] TC_S_VAR = 4'd7;
    localparam logic [3:0] TC_S8    = 4'd8;
    localparam logic [3:0] TC_S16   = 4'd9;
    localparam logic [3:0] TC_S32   = 4'd10;
    localparam logic [3:0] TC_S64   = 4'd11;
    localparam logic [3:0] TC_F_VAR = 4'd12;
    localparam logic [3:0] TC_F32   = 4'd13;
    localparam logic [3:0] TC_F64   = 4'd14;

    // |x| threshold for float to bool, as f64 bits of 0.001
    localparam logic [62:0] BOOL_THRESH = 63'h3F50624DD2F1A9FC;

    typedef enum logic [2:0] {
        CLS_BAD,
        CLS_BOOL,
        CLS_UINT,
        CLS_SINT,
        CLS_FLT
    } t_cls;

    typedef struct packed {
        logic        sign;
        logic [10:0] expf;
        logic [63:0] sig;
        logic        stk;
        logic        dbl;
    } t_rnd;

    function automatic t_cls type_class(input logic [3:0] t);
        t_cls c;
        c = CLS_BAD;
        if (t == TC_BOOL) c = CLS_BOOL;
        else if (t inside {[TC_U_VAR:TC_U64]}) c = CLS_UINT;
        else if (t inside {[TC_S_VAR:TC_S64]}) c = CLS_SINT;
        else if (t inside {[TC_F_VAR:TC_F64]}) c = CLS_FLT;
        return c;
    endfunction

    function automatic logic len_is_var(input logic [3:0] t);
        return (t == TC_U_VAR) || (t == TC_S_VAR) || (t == TC_F_VAR);
    endfunction

    function automatic logic [3:0] fixed_len(input logic [3:0] t);
        logic [3:0] n;
        case (t)
            TC_BOOL, TC_U8, TC_S8:    n = 4'd1;
            TC_U16, TC_S16:           n = 4'd2;
            TC_U32, TC_S32, TC_F32:   n = 4'd4;
            TC_U64, TC_S64, TC_F64:   n = 4'd8;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        if (n >= 4'd8) m = '1;
        else m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        return m;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] m;
        logic [63:0] r;
        m = 64'd1 << ({n[2:0], 3'b000} - 6'd1);
        if (n == 4'd0) r = '0;
        else if (n >= 4'd8) r = v;
        else r = ((v & byte_mask(n)) ^ m) - m;
        return r;
    endfunction

    function automatic logic [63:0] f32_to_f64(input logic [31:0] b);
        logic        s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  p;
        logic [22:0] fr;
        logic [63:0] r;
        s = b[31];
        e = b[30:23];
        m = b[22:0];
        p = '0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) p = 5'(i);
        end
        fr = m << (5'd23 - p);
        if (e == 8'hFF) begin
            if (m != '0) r = {s, 11'h7FF, m | 23'h400000, 29'b0};
            else r = {s, 11'h7FF, 52'b0};
        end else if (e == 8'h00) begin
            if (m == '0) r = {s, 63'b0};
            else r = {s, 11'(p) + 11'd874, fr, 29'b0};
        end else begin
            r = {s, 11'(e) + 11'd896, m, 29'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ntc_round.sv
`default_nettype none

module ntc_round
    import ntc_pkg::*;
(
    input  wire t_rnd        i_rnd,
    output logic [63:0]      o_bits
);

    logic        inc32;
    logic        inc64;
    logic [30:0] p32;
    logic [62:0] p64;

    always_comb begin
        inc32 = i_rnd.sig[39] & ((|i_rnd.sig[38:0]) | i_rnd.stk | i_rnd.sig[40]);
        inc64 = i_rnd.sig[10] & ((|i_rnd.sig[9:0]) | i_rnd.stk | i_rnd.sig[11]);
        p32   = {i_rnd.expf[7:0], i_rnd.sig[62:40]} + 31'(inc32);
        p64   = {i_rnd.expf, i_rnd.sig[62:11]} + 63'(inc64);
        if (i_rnd.dbl) o_bits = {i_rnd.sign, p64};
        else o_bits = {32'b0, i_rnd.sign, p32};
    end

endmodule

`default_nettype wire

### rtl/numeric_type_converter.sv
// Pipeline: 4 register stages (decode, prepare, shift, round/check); the result
// is driven from the round/check stage registers.
// Throughput: one transaction per cycle unless stalled; each stage advances
// when the next is empty or moving, so bubbles close up under backpressure.
// Reset: synchronous, active low; clears all stage valid bits.
`default_nettype none

module numeric_type_converter
    import ntc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [3:0]  i_source_type,
    input  wire  [3:0]  i_source_length,
    input  wire  [63:0] i_source_bytes,
    input  wire  [3:0]  i_target_type,
    input  wire  [3:0]  i_target_length,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_converted_ok,
    output logic [63:0] o_result_bytes
);

    typedef struct packed {
        logic        fail;
        t_cls        sc;
        t_cls        tc;
        logic [3:0]  tl;
        logic [63:0] iv;
        logic        neg;
        logic [63:0] fb;
    } t_s1;

    typedef struct packed {
        logic        fail;
        t_cls        sc;
        t_cls        tc;
        logic [3:0]  tl;
        logic [63:0] iv;
        logic        neg;
        logic [63:0] fb;
        logic        bres;
        logic        negf;
        logic        fi_zero;
        logic        fi_left;
        logic [5:0]  fi_sh;
        logic [63:0] mag;
        logic [6:0]  lz;
        logic        sub32;
        logic        ovf32;
        logic [4:0]  rsh;
        logic [7:0]  e32;
    } t_s2;

    typedef struct packed {
        logic        fail;
        t_cls        sc;
        t_cls        tc;
        logic [3:0]  tl;
        logic [63:0] iv;
        logic        neg;
        logic [63:0] fb;
        logic        bres;
        logic        negf;
        logic [63:0] fi_mag;
        t_rnd        rnd;
        logic        spec;
        logic [31:0] spec_val;
    } t_s3;

    logic r_v1, r_v2, r_v3, r_vo;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    logic        r_ok, n_ok;
    logic [63:0] r_res, n_res;
    logic e1, e2, e3;
    logic [63:0] rnd_bits;

    assign e3      = !r_vo || i_ready;
    assign e2      = !r_v3 || e3;
    assign e1      = !r_v2 || e2;
    assign o_ready = !r_v1 || e1;

    // stage 1: decode and length checks
    always_comb begin
        n_s1.sc   = type_class(i_source_type);
        n_s1.tc   = type_class(i_target_type);
        n_s1.tl   = i_target_length;
        n_s1.fail = (i_source_length > 4'd8) || (i_target_length > 4'd8)
            || (n_s1.sc == CLS_BAD) || (n_s1.tc == CLS_BAD)
            || (!len_is_var(i_source_type) && i_source_length != fixed_len(i_source_type))
            || (!len_is_var(i_target_type) && i_target_length != fixed_len(i_target_type))
            || (n_s1.sc != CLS_BOOL && i_source_length == 4'd0)
            || (n_s1.sc == CLS_FLT && i_source_length != 4'd4 && i_source_length != 4'd8)
            || (n_s1.tc == CLS_FLT && i_target_length != 4'd4 && i_target_length != 4'd8);
        n_s1.neg = 1'b0;
        case (n_s1.sc)
            CLS_BOOL: n_s1.iv = {63'b0, i_source_bytes[7:0] != 8'd0};
            CLS_UINT: n_s1.iv = i_source_bytes & byte_mask(i_source_length);
            CLS_SINT: begin
                n_s1.iv  = sign_ext(i_source_bytes, i_source_length);
                n_s1.neg = n_s1.iv[63];
            end
            default:  n_s1.iv = '0;
        endcase
        if (i_source_length == 4'd4) n_s1.fb = f32_to_f64(i_source_bytes[31:0]);
        else n_s1.fb = i_source_bytes;
    end

    // stage 2: classify float, abs value and leading zeros
    always_comb begin
        logic        fs;
        logic [10:0] fe;
        logic [51:0] fm;
        logic        nan;
        logic        ge1;
        logic        fi_bad;
        logic signed [11:0] be32;
        fs   = r_s1.fb[63];
        fe   = r_s1.fb[62:52];
        fm   = r_s1.fb[51:0];
        nan  = (fe == 11'h7FF) && (fm != '0);
        ge1  = fe >= 11'd1023;
        be32 = $signed({1'b0, fe}) - 12'sd896;

        n_s2.sc   = r_s1.sc;
        n_s2.tc   = r_s1.tc;
        n_s2.tl   = r_s1.tl;
        n_s2.iv   = r_s1.iv;
        n_s2.neg  = r_s1.neg;
        n_s2.fb   = r_s1.fb;
        n_s2.negf = fs && ge1;
        fi_bad = nan
            || (n_s2.negf && (r_s1.tc == CLS_UINT || fe > 11'd1086
                || (fe == 11'd1086 && fm != '0)))
            || (!fs && fe >= 11'd1087);
        n_s2.fail = r_s1.fail || (r_s1.sc == CLS_FLT
            && (r_s1.tc == CLS_UINT || r_s1.tc == CLS_SINT) && fi_bad);
        if (r_s1.sc == CLS_FLT) n_s2.bres = !nan && (r_s1.fb[62:0] > BOOL_THRESH);
        else n_s2.bres = r_s1.iv != '0;
        n_s2.fi_zero = !ge1;
        n_s2.fi_left = fe >= 11'd1075;
        if (fe >= 11'd1075) n_s2.fi_sh = 6'(fe - 11'd1075);
        else n_s2.fi_sh = 6'(11'd1075 - fe);
        n_s2.mag = r_s1.neg ? (64'd0 - r_s1.iv) : r_s1.iv;
        n_s2.lz  = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (n_s2.mag[i]) n_s2.lz = 7'(63 - i);
        end
        n_s2.sub32 = be32 <= 12'sd0;
        n_s2.ovf32 = be32 >= 12'sd255;
        if (be32 < -12'sd30) n_s2.rsh = 5'd31;
        else n_s2.rsh = 5'(12'sd1 - be32);
        n_s2.e32 = be32[7:0];
    end

    // stage 3: alignment shifts
    always_comb begin
        logic [63:0] sig0;
        logic [63:0] sig53;
        sig53 = {11'b0, 1'b1, r_s2.fb[51:0]};
        sig0  = (r_s2.fb[62:52] == 11'd0) ? 64'd0 : {1'b1, r_s2.fb[51:0], 11'b0};

        n_s3.fail = r_s2.fail;
        n_s3.sc   = r_s2.sc;
        n_s3.tc   = r_s2.tc;
        n_s3.tl   = r_s2.tl;
        n_s3.iv   = r_s2.iv;
        n_s3.neg  = r_s2.neg;
        n_s3.fb   = r_s2.fb;
        n_s3.bres = r_s2.bres;
        n_s3.negf = r_s2.negf;
        if (r_s2.fi_zero) n_s3.fi_mag = '0;
        else if (r_s2.fi_left) n_s3.fi_mag = sig53 << r_s2.fi_sh;
        else n_s3.fi_mag = sig53 >> r_s2.fi_sh;

        n_s3.rnd.dbl  = r_s2.tl == 4'd8;
        n_s3.spec     = 1'b0;
        n_s3.spec_val = {r_s2.fb[63], 8'hFF, 23'b0};
        if (r_s2.sc == CLS_FLT) begin
            n_s3.rnd.sign = r_s2.fb[63];
            if (r_s2.sub32) begin
                n_s3.rnd.sig  = sig0 >> r_s2.rsh;
                n_s3.rnd.stk  = (sig0 & ~({64{1'b1}} << r_s2.rsh)) != '0;
                n_s3.rnd.expf = '0;
            end else begin
                n_s3.rnd.sig  = sig0;
                n_s3.rnd.stk  = 1'b0;
                n_s3.rnd.expf = {3'b0, r_s2.e32};
            end
            if (r_s2.fb[62:52] == 11'h7FF && r_s2.fb[51:0] != '0) begin
                n_s3.spec     = 1'b1;
                n_s3.spec_val = {r_s2.fb[63], 8'hFF, 1'b1, r_s2.fb[50:29]};
            end else if (r_s2.ovf32) begin
                n_s3.spec = 1'b1;
            end
        end else begin
            n_s3.rnd.sign = r_s2.neg;
            n_s3.rnd.sig  = r_s2.mag << r_s2.lz;
            n_s3.rnd.stk  = 1'b0;
            if (r_s2.mag == '0) n_s3.rnd.expf = '0;
            else n_s3.rnd.expf = (n_s3.rnd.dbl ? 11'd1023 : 11'd127)
                + (11'd63 - 11'(r_s2.lz));
        end
    end

    ntc_round u_round (
        .i_rnd  (r_s3.rnd),
        .o_bits (rnd_bits)
    );

    // stage 4: rounding, range check, byte masking
    always_comb begin
        logic [63:0] ivx;
        logic        ng;
        logic        rng_ok;
        logic [63:0] val;
        if (r_s3.sc == CLS_FLT) begin
            ivx = r_s3.negf ? (64'd0 - r_s3.fi_mag) : r_s3.fi_mag;
            ng  = r_s3.negf;
        end else begin
            ivx = r_s3.iv;
            ng  = r_s3.neg;
        end
        if (r_s3.tc == CLS_UINT) rng_ok = !ng && ((ivx & ~byte_mask(r_s3.tl)) == '0);
        else rng_ok = (ng || !ivx[63]) && (sign_ext(ivx, r_s3.tl) == ivx);
        case (r_s3.tc)
            CLS_BOOL: begin
                val  = {63'b0, r_s3.bres};
                n_ok = 1'b1;
            end
            CLS_UINT, CLS_SINT: begin
                val  = ivx;
                n_ok = rng_ok;
            end
            CLS_FLT: begin
                n_ok = 1'b1;
                if (r_s3.sc == CLS_FLT && r_s3.tl == 4'd8) val = r_s3.fb;
                else if (r_s3.spec) val = {32'b0, r_s3.spec_val};
                else val = rnd_bits;
            end
            default: begin
                val  = '0;
                n_ok = 1'b0;
            end
        endcase
        if (r_s3.fail) n_ok = 1'b0;
        n_res = n_ok ? (val & byte_mask(r_s3.tl)) : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (e1) r_v2 <= r_v1;
            if (e2) r_v3 <= r_v2;
            if (e3) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_s1 <= n_s1;
        if (e1) r_s2 <= n_s2;
        if (e2) r_s3 <= n_s3;
        if (e3) begin
            r_ok  <= n_ok;
            r_res <= n_res;
        end
    end

    assign o_valid        = r_vo;
    assign o_converted_ok = r_ok;
    assign o_result_bytes = r_res;

endmodule

`default_nettype wire

### sim/numeric_type_converter_test.sv
`default_nettype none

module numeric_type_converter_test;
    import ntc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] LEN_VAR = 4'hF;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         HOLD_CYCLES = 400;

    typedef struct {
        logic [3:0]  st;
        logic [3:0]  sl;
        logic [63:0] sb;
        logic [3:0]  tt;
        logic [3:0]  tl;
    } t_conv_req;

    typedef struct packed {
        logic        ok;
        logic [63:0] bytes;
    } t_conv_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        drv_valid = 1'b0;
    logic        drv_ready = 1'b0;
    logic [3:0]  drv_st = '0;
    logic [3:0]  drv_sl = '0;
    logic [63:0] drv_sb = '0;
    logic [3:0]  drv_tt = '0;
    logic [3:0]  drv_tl = '0;
    wire         o_ready;
    wire         o_valid;
    wire         o_converted_ok;
    wire  [63:0] o_result_bytes;

    t_conv_req   pending_items[$];
    t_conv_res   expected_results[$];
    int          mismatches = 0;
    int          cyc = 0;
    int          send_idle = 0;
    int          rdy_stall = 0;
    int          hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic        in_taken = 1'b0;

    numeric_type_converter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (drv_valid),
        .o_ready        (o_ready),
        .i_source_type  (drv_st),
        .i_source_length(drv_sl),
        .i_source_bytes (drv_sb),
        .i_target_type  (drv_tt),
        .i_target_length(drv_tl),
        .o_valid        (o_valid),
        .i_ready        (drv_ready),
        .o_converted_ok (o_converted_ok),
        .o_result_bytes (o_result_bytes)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] low_bytes(input logic [3:0] n);
        if (n >= 4'd8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic logic [63:0] extend_sign(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] top;
        if (n == 4'd0) return '0;
        if (n >= 4'd8) return v;
        top = 64'd1 << (8 * n - 1);
        return ((v & low_bytes(n)) ^ top) - top;
    endfunction

    function automatic t_cls class_of(input logic [3:0] t);
        case (t)
            TC_BOOL:                                return CLS_BOOL;
            TC_U_VAR, TC_U8, TC_U16, TC_U32, TC_U64: return CLS_UINT;
            TC_S_VAR, TC_S8, TC_S16, TC_S32, TC_S64: return CLS_SINT;
            TC_F_VAR, TC_F32, TC_F64:               return CLS_FLT;
            default:                                return CLS_BAD;
        endcase
    endfunction

    function automatic logic [3:0] size_of(input logic [3:0] t);
        case (t)
            TC_BOOL, TC_U8, TC_S8:  return 4'd1;
            TC_U16, TC_S16:         return 4'd2;
            TC_U32, TC_S32, TC_F32: return 4'd4;
            TC_U64, TC_S64, TC_F64: return 4'd8;
            default:                return LEN_VAR;
        endcase
    endfunction

    // round-to-nearest-even of an integer magnitude into f32 or f64
    function automatic logic [63:0] int_to_float(input logic neg, input logic [63:0] mag,
                                                 input logic dbl);
        int          p;
        int          fw;
        int          sh;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == '0) return '0;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) p = i;
        end
        fw = dbl ? 52 : 23;
        if (p <= fw) begin
            kept = mag << (fw - p);
        end else begin
            sh = p - fw;
            kept = mag >> sh;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
            if (kept[fw + 1]) begin
                kept = kept >> 1;
                p = p + 1;
            end
        end
        if (dbl) return {neg, 11'(p + 1023), kept[51:0]};
        return {32'b0, neg, 8'(p + 127), kept[22:0]};
    endfunction

    function automatic logic [63:0] widen(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [22:0] fr;
        int          p;
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hFF) begin
            if (m != '0) return {b[31], 11'h7FF, 1'b1, m[21:0], 29'b0};
            return {b[31], 11'h7FF, 52'b0};
        end
        if (e == 8'h00) begin
            if (m == '0) return {b[31], 63'b0};
            p = 0;
            for (int i = 0; i < 23; i++) begin
                if (m[i]) p = i;
            end
            fr = m << (23 - p);
            return {b[31], 11'(p + 874), fr, 29'b0};
        end
        return {b[31], 11'(int'(e) + 896), m, 29'b0};
    endfunction

    function automatic logic [31:0] narrow(input logic [63:0] b);
        logic [10:0] e;
        logic [51:0] m;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          e32;
        int          sh;
        e = b[62:52];
        m = b[51:0];
        if (e == 11'h7FF) begin
            if (m != '0) return {b[63], 8'hFF, 1'b1, m[50:29]};
            return {b[63], 8'hFF, 23'b0};
        end
        if (e == 11'h000) return {b[63], 31'b0};
        e32 = int'(e) - 896;
        if (e32 >= 255) return {b[63], 8'hFF, 23'b0};
        sig = {11'b0, 1'b1, m};
        sh = (e32 >= 1) ? 29 : 30 - e32;
        if (sh >= 64) return {b[63], 31'b0};
        kept = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        mag = (e32 >= 1) ? (64'(e32 - 1) << 23) + kept : kept;
        if (mag >= 64'h7F800000) return {b[63], 8'hFF, 23'b0};
        return {b[63], mag[30:0]};
    endfunction

    function automatic t_conv_res convert(input t_conv_req q);
        t_conv_res   r;
        t_cls        sc;
        t_cls        tc;
        logic [63:0] iv;
        logic [63:0] fb;
        logic [63:0] res;
        logic [63:0] mag;
        logic        neg;
        logic        ok;
        int          ex;
        real         dv;
        r = '0;
        iv = '0;
        fb = '0;
        res = '0;
        neg = 1'b0;
        ok = 1'b0;
        if (q.sl > 4'd8 || q.tl > 4'd8) return r;
        sc = class_of(q.st);
        tc = class_of(q.tt);
        if (sc == CLS_BAD || tc == CLS_BAD) return r;
        if (size_of(q.st) != LEN_VAR && q.sl != size_of(q.st)) return r;
        if (size_of(q.tt) != LEN_VAR && q.tl != size_of(q.tt)) return r;
        if (sc != CLS_BOOL && q.sl == 4'd0) return r;
        case (sc)
            CLS_BOOL: iv = {63'b0, q.sb[7:0] != 8'h00};
            CLS_UINT: iv = q.sb & low_bytes(q.sl);
            CLS_SINT: begin
                iv = extend_sign(q.sb, q.sl);
                neg = iv[63];
            end
            default: begin
                if (q.sl == 4'd4) fb = widen(q.sb[31:0]);
                else if (q.sl == 4'd8) fb = q.sb;
                else return r;
            end
        endcase
        if (tc == CLS_BOOL) begin
            if (sc == CLS_FLT) begin
                dv = $bitstoreal(fb);
                res = {63'b0, (dv > 0.001) || (dv < -0.001)};
            end else begin
                res = {63'b0, iv != '0};
            end
            ok = 1'b1;
        end else if (tc == CLS_FLT) begin
            if (q.tl != 4'd4 && q.tl != 4'd8) return r;
            if (sc == CLS_FLT) res = (q.tl == 4'd4) ? {32'b0, narrow(fb)} : fb;
            else res = int_to_float(neg, neg ? -iv : iv, q.tl == 4'd8);
            ok = 1'b1;
        end else begin
            if (sc == CLS_FLT) begin
                if (fb[62:52] == 11'h7FF) return r;
                if (fb[62:52] < 11'd1023) begin
                    iv = '0;
                    neg = 1'b0;
                end else begin
                    ex = int'(fb[62:52]) - 1023;
                    if (fb[63]) begin
                        if (tc == CLS_UINT || ex > 63 || (ex == 63 && fb[51:0] != '0))
                            return r;
                    end else if (ex >= 64) begin
                        return r;
                    end
                    mag = {11'b0, 1'b1, fb[51:0]};
                    mag = (ex >= 52) ? mag << (ex - 52) : mag >> (52 - ex);
                    neg = fb[63];
                    iv = neg ? -mag : mag;
                end
            end
            if (tc == CLS_UINT) ok = !neg && (iv & ~low_bytes(q.tl)) == '0;
            else ok = (neg || !iv[63]) && extend_sign(iv, q.tl) == iv;
            res = iv;
        end
        if (ok) begin
            r.ok = 1'b1;
            r.bytes = res & low_bytes(q.tl);
        end
        return r;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] pick_len(input logic [3:0] t);
        if (size_of(t) != LEN_VAR) return size_of(t);
        if (t == TC_F_VAR && $urandom_range(9) != 0) return $urandom_range(1) ? 4'd8 : 4'd4;
        return 4'($urandom_range(8));
    endfunction

    function automatic logic [63:0] pick_value(input logic [3:0] t, input logic [3:0] n);
        logic [63:0] v;
        logic [10:0] e11;
        logic [7:0]  e8;
        int          k;
        v = rnd64();
        case (class_of(t))
            CLS_FLT: begin
                case ($urandom_range(4))
                    0: e11 = 11'h000;
                    1: e11 = 11'h7FF;
                    2: e11 = 11'($urandom_range(1000, 1090));
                    3: e11 = 11'($urandom_range(870, 1160));
                    default: e11 = 11'($urandom);
                endcase
                case ($urandom_range(4))
                    0: e8 = 8'h00;
                    1: e8 = 8'hFF;
                    2: e8 = 8'($urandom_range(110, 195));
                    default: e8 = 8'($urandom);
                endcase
                if (n == 4'd4) begin
                    v[30:23] = e8;
                    if ($urandom_range(3) == 0) v[22:0] = '0;
                end else begin
                    v[62:52] = e11;
                    if ($urandom_range(3) == 0) v[51:0] = '0;
                end
            end
            CLS_BOOL: if ($urandom_range(1)) v[7:0] = 8'h00;
            default: begin
                case ($urandom_range(3))
                    0: ;
                    1: v = v >> $urandom_range(63);
                    2: begin
                        k = $urandom_range(1, 8);
                        v = 64'd1 << (8 * k - 1);
                        case ($urandom_range(3))
                            0: ;
                            1: v = v - 64'd1;
                            2: v = -v;
                            default: v = -v - 64'd1;
                        endcase
                    end
                    default: v = $urandom_range(1) ? '1 : '0;
                endcase
                v = (v & low_bytes(n)) | (rnd64() & ~low_bytes(n));
            end
        endcase
        return v;
    endfunction

    function automatic t_conv_req random_request();
        t_conv_req q;
        if ($urandom_range(99) < 6) begin
            q.st = 4'($urandom);
            q.sl = 4'($urandom);
            q.tt = 4'($urandom);
            q.tl = 4'($urandom);
            q.sb = rnd64();
        end else begin
            q.st = 4'($urandom_range(1, 14));
            q.tt = 4'($urandom_range(1, 14));
            q.sl = pick_len(q.st);
            q.tl = pick_len(q.tt);
            q.sb = pick_value(q.st, q.sl);
        end
        return q;
    endfunction

    task automatic add_item(input logic [3:0] st, input logic [3:0] sl, input logic [63:0] sb,
                            input logic [3:0] tt, input logic [3:0] tl);
        t_conv_req q;
        q.st = st;
        q.sl = sl;
        q.sb = sb;
        q.tt = tt;
        q.tl = tl;
        pending_items.push_back(q);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || drv_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n, input logic hold);
        send_idle = idle;
        rdy_stall = stall;
        hold_req = hold;
        for (int i = 0; i < n; i++) pending_items.push_back(random_request());
        drain();
    endtask

    always @(negedge i_clk) begin : drive
        t_conv_req q;
        if (i_rst_n) begin
            if (!drv_valid || in_taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
                    q = pending_items.pop_front();
                    drv_valid <= 1'b1;
                    drv_st <= q.st;
                    drv_sl <= q.sl;
                    drv_sb <= q.sb;
                    drv_tt <= q.tt;
                    drv_tl <= q.tl;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
            drv_ready <= (hold_left == 0) && ($urandom_range(99) >= rdy_stall);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_conv_req q;
        t_conv_res want;
        in_taken = i_rst_n && drv_valid && (o_ready === 1'b1);
        if (in_taken) begin
            q.st = drv_st;
            q.sl = drv_sl;
            q.sb = drv_sb;
            q.tt = drv_tt;
            q.tl = drv_tl;
            expected_results.push_back(convert(q));
        end
        if (i_rst_n && drv_ready && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction ok=%b bytes=%h",
                         $time, o_converted_ok, o_result_bytes);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_converted_ok !== want.ok) begin
                    $display("%0t: converted_ok expected %b actual %b",
                             $time, want.ok, o_converted_ok);
                    mismatches++;
                end
                if (o_result_bytes !== want.bytes) begin
                    $display("%0t: result_bytes expected %h actual %h",
                             $time, want.bytes, o_result_bytes);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_item(TC_BOOL, 4'd1, 64'hFFFF_FFFF_FFFF_FF01, TC_U8, 4'd1);
        add_item(TC_BOOL, 4'd1, 64'hFFFF_FFFF_FFFF_FF00, TC_F64, 4'd8);
        add_item(TC_U64, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, TC_S64, 4'd8);
        add_item(TC_U64, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, TC_F32, 4'd4);
        add_item(TC_S8, 4'd1, 64'h0000_0000_0000_0080, TC_U8, 4'd1);
        add_item(TC_U8, 4'd1, 64'h0000_0000_0000_00FF, TC_S8, 4'd1);
        add_item(TC_S_VAR, 4'd3, 64'hAAAA_AAAA_AAFF_FF80, TC_S8, 4'd1);
        add_item(TC_S64, 4'd8, 64'h8000_0000_0000_0000, TC_F64, 4'd8);
        add_item(TC_F64, 4'd8, 64'h7FF8_0000_0000_0001, TC_S32, 4'd4);
        add_item(TC_F64, 4'd8, 64'h7FF0_0000_0000_0000, TC_U64, 4'd8);
        add_item(TC_F64, 4'd8, 64'hBFF8_0000_0000_0000, TC_S16, 4'd2);
        add_item(TC_F64, 4'd8, 64'hC3E0_0000_0000_0000, TC_S64, 4'd8);
        add_item(TC_F64, 4'd8, 64'h43E0_0000_0000_0000, TC_U64, 4'd8);
        add_item(TC_F64, 4'd8, 64'h7FEF_FFFF_FFFF_FFFF, TC_F32, 4'd4);
        add_item(TC_F64, 4'd8, 64'hFFF4_0000_0000_0000, TC_F_VAR, 4'd4);
        add_item(TC_F32, 4'd4, 64'h1234_5678_0000_0001, TC_F64, 4'd8);
        add_item(TC_F64, 4'd8, 64'h3F40_624D_D2F1_A9FC, TC_BOOL, 4'd1);
        add_item(TC_F32, 4'd4, 64'h0000_0000_3B03_126F, TC_BOOL, 4'd1);
        add_item(4'd0, 4'd1, 64'h1, TC_U8, 4'd1);
        add_item(TC_U8, 4'd1, 64'h1, 4'd15, 4'd1);
        add_item(TC_U_VAR, 4'd9, 64'h1, TC_U64, 4'd8);
        add_item(TC_U_VAR, 4'd0, 64'h0, TC_U8, 4'd1);
        add_item(TC_U_VAR, 4'd2, 64'hFFFF_FFFF_FFFF_0000, TC_U_VAR, 4'd0);
        add_item(TC_F_VAR, 4'd3, 64'h3F80_0000, TC_S32, 4'd4);
        drain();

        run_phase(0, 0, 340, 1'b0);
        run_phase(55, 0, 340, 1'b0);
        run_phase(0, 55, 340, 1'b0);
        run_phase(35, 35, 340, 1'b0);
        run_phase(0, 0, 340, 1'b1);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/ntc_pkg.sv
rtl/ntc_round.sv
rtl/numeric_type_converter.sv
sim/numeric_type_converter_test.sv
